FILE: rtl/core/wgm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard glob matcher package
// Shared widths, character codes, register indexes and the cell-to-cell word.
// ----------------------------------------------------------------------------
package wgm_pkg;

    localparam int PATTERN_MAX_DEFAULT = 32;
    localparam int LEN_W               = 6;
    localparam int CFG_INDEX_W         = 3;
    localparam int CFG_DATA_W          = 64;
    localparam int PATTERN_WORDS       = 4;
    localparam int CHAR_W              = 8;

    localparam logic [CHAR_W-1:0] CH_NUL      = 8'h00;
    localparam logic [CHAR_W-1:0] CH_STAR     = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_QUESTION = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_DOT      = 8'h2E;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LENGTH = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LO     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MID_LO = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_MID_HI = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HI     = 3'd4;

    // Passed from each cell to its right-hand neighbour.
    typedef struct packed {
        logic alive;   // every earlier position is inside the effective pattern
        logic carry;   // star closure into the next position
        logic adv;     // one-character advance into the next position
    } nb_t;

endpackage
`default_nettype wire

FILE: rtl/core/wildcard_glob_matcher_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard glob matcher
// Streams subject bytes through a row of pattern-position cells.
// ----------------------------------------------------------------------------
// Accepts one subject byte per clock unless in_stall is raised. Each pattern
// position is a cell holding its activity bit; star closure ripples along the
// row like a carry, so a byte is fully absorbed in the cycle it is taken. A
// zero byte ends the string: the verdict appears on the output register the
// cycle after, and the cells rearm at once, so the next string may follow
// directly. After a write to any of the five pattern registers the input is
// held off while the cells reload their decoded pattern characters (also
// after reset); writes to unused indexes are dropped and hold nothing off.
// Pattern stops at the first zero byte or at pattern_length, whichever is
// first; lengths above PATTERN_MAX are treated as PATTERN_MAX.
// ----------------------------------------------------------------------------
module wildcard_glob_matcher_top #(
    parameter int PATTERN_MAX = wgm_pkg::PATTERN_MAX_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_stall,
    input  wire logic [wgm_pkg::CHAR_W-1:0]       subject_byte,
    output logic                                  out_valid,
    input  wire logic                             out_stall,
    output logic                                  matched,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [wgm_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [wgm_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int LW = wgm_pkg::LEN_W;
    localparam int BYTES_PER_WORD = wgm_pkg::CFG_DATA_W / wgm_pkg::CHAR_W;

    logic [LW-1:0]                                            length_reg;
    logic [wgm_pkg::PATTERN_WORDS-1:0][wgm_pkg::CFG_DATA_W-1:0] pattern_reg;
    logic                                                     settle_reg;
    logic                                                     settle_next;
    logic                                                     raw_last_reg;
    logic                                                     raw_last_next;
    logic                                                     end_last_reg;
    logic                                                     out_valid_reg;
    logic                                                     out_valid_next;
    logic                                                     matched_reg;
    logic                                                     matched_next;

    wgm_pkg::nb_t                chain [PATTERN_MAX+1];
    logic [PATTERN_MAX-1:0]      end_hits;
    logic                        accept;
    logic                        term;
    logic                        cfg_hit;
    logic                        load;
    logic                        step;
    logic                        closed_last;
    logic                        verdict;

    assign cfg_ready = 1'b1;
    assign cfg_hit   = cfg_valid & cfg_ready & (cfg_index <= wgm_pkg::REG_PATTERN_HI);

    assign in_stall  = settle_reg | (out_valid_reg & out_stall);
    assign accept    = in_valid & ~in_stall;
    assign term      = (subject_byte == wgm_pkg::CH_NUL);
    assign load      = (accept & term) | cfg_hit;
    assign step      = accept & ~term;

    assign chain[0] = '{alive: 1'b1, carry: 1'b0, adv: 1'b0};

    for (genvar p = 0; p < PATTERN_MAX; p++)
    begin : g_cell
        wgm_cell #(
            .START (p == 0)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .load    (load),
            .step    (step),
            .subj    (subject_byte),
            .pat     (pattern_reg[p / BYTES_PER_WORD]
                          [(p % BYTES_PER_WORD) * wgm_pkg::CHAR_W +: wgm_pkg::CHAR_W]),
            .lim_ok  (length_reg > LW'(p)),
            .left    (chain[p]),
            .right   (chain[p+1]),
            .end_hit (end_hits[p])
        );
    end

    // final position has no pattern character: it only receives advances and star closure
    always_comb
    begin
        closed_last = raw_last_reg | chain[PATTERN_MAX].carry;
        verdict     = (|end_hits) | (closed_last & end_last_reg);

        priority if (load)
        begin
            raw_last_next = 1'b0;
        end
        else if (step)
        begin
            raw_last_next = chain[PATTERN_MAX].adv;
        end
        else
        begin
            raw_last_next = raw_last_reg;
        end

        settle_next = cfg_hit;

        priority if (accept & term)
        begin
            out_valid_next = 1'b1;
            matched_next   = verdict;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
            matched_next   = matched_reg;
        end
        else
        begin
            out_valid_next = out_valid_reg;
            matched_next   = matched_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            pattern_reg   <= '0;
            settle_reg    <= 1'b1;
            raw_last_reg  <= 1'b0;
            end_last_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            settle_reg    <= settle_next;
            raw_last_reg  <= raw_last_next;
            end_last_reg  <= chain[PATTERN_MAX].alive;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    wgm_pkg::REG_PATTERN_LENGTH:
                    begin
                        length_reg <= cfg_data[LW-1:0];
                    end
                    wgm_pkg::REG_PATTERN_LO:
                    begin
                        pattern_reg[0] <= cfg_data;
                    end
                    wgm_pkg::REG_PATTERN_MID_LO:
                    begin
                        pattern_reg[1] <= cfg_data;
                    end
                    wgm_pkg::REG_PATTERN_MID_HI:
                    begin
                        pattern_reg[2] <= cfg_data;
                    end
                    wgm_pkg::REG_PATTERN_HI:
                    begin
                        pattern_reg[3] <= cfg_data;
                    end
                    default:
                    begin
                        length_reg <= length_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        matched_reg <= matched_next;
    end

    assign out_valid = out_valid_reg;
    assign matched   = matched_reg;

endmodule
`default_nettype wire

FILE: rtl/core/wgm_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Wildcard glob matcher cell
// One pattern position: holds its activity bit and decoded pattern character.
// ----------------------------------------------------------------------------
module wgm_cell #(
    parameter bit START = 1'b0
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        load,
    input  wire logic                        step,
    input  wire logic [wgm_pkg::CHAR_W-1:0]  subj,
    input  wire logic [wgm_pkg::CHAR_W-1:0]  pat,
    input  wire logic                        lim_ok,
    input  wire wgm_pkg::nb_t                left,
    output wgm_pkg::nb_t                     right,
    output logic                             end_hit
);

    logic                       is_star;
    logic                       en_c;
    logic                       hit;
    logic                       closed;
    logic                       raw_reg;
    logic                       raw_next;
    logic                       en_reg;
    logic                       star_reg;
    logic                       end_reg;
    logic                       qm_reg;
    logic [wgm_pkg::CHAR_W-1:0] lit_reg;

    always_comb
    begin
        is_star = (pat == wgm_pkg::CH_STAR);
        en_c    = left.alive & lim_ok & (pat != wgm_pkg::CH_NUL);
        hit     = (qm_reg & (subj != wgm_pkg::CH_DOT)) | (lit_reg == subj);
        // stored bit is pre-closure; closure ripples in from the left
        closed  = raw_reg | left.carry;

        right.alive = en_c;
        right.carry = closed & star_reg;
        right.adv   = closed & en_reg & ~star_reg & hit;
        end_hit     = closed & end_reg;

        priority if (load)
        begin
            raw_next = START;
        end
        else if (step)
        begin
            raw_next = (closed & star_reg) | left.adv;
        end
        else
        begin
            raw_next = raw_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            raw_reg  <= START;
            en_reg   <= 1'b0;
            star_reg <= 1'b0;
            end_reg  <= 1'b0;
            qm_reg   <= 1'b0;
        end
        else
        begin
            raw_reg  <= raw_next;
            en_reg   <= en_c;
            star_reg <= en_c & is_star;
            end_reg  <= left.alive & ~en_c;
            qm_reg   <= en_c & (pat == wgm_pkg::CH_QUESTION);
        end
    end

    always_ff @(posedge clk)
    begin
        lit_reg <= pat;
    end

endmodule
`default_nettype wire

FILE: tb/sv/tb_wildcard_glob_matcher_top.sv
// ----------------------------------------------------------------------------
// Wildcard glob matcher testbench
// Streams subject strings through the matcher under a series of patterns and
// checks every verdict against an in-bench position-set tracker.
// ----------------------------------------------------------------------------
module tb_wildcard_glob_matcher_top;
    timeunit 1ns;
    timeprecision 1ps;

    import wgm_pkg::*;

    localparam int PATTERN_MAX   = PATTERN_MAX_DEFAULT;
    localparam int RANDOM_ITEMS  = 1150;
    localparam int STRING_TARGET = 75;
    localparam int SETTLE_CYCLES = 4;
    localparam int CYCLE_LIMIT   = 200000;

    localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = '1;

    typedef logic [PATTERN_MAX:0] pos_set_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [CHAR_W-1:0]      subject_byte = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic                   matched;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;

    // tracker state
    logic [LEN_W-1:0]       pattern_len = '0;
    logic [CFG_DATA_W-1:0]  pattern_words [PATTERN_WORDS];
    pos_set_t               active_pos;

    logic [CHAR_W-1:0]      subject_queue [$];
    logic                   verdict_queue [$];
    bit                     in_taken = 1'b0;
    int                     send_idle_pct = 0;
    int                     recv_idle_pct = 0;
    int                     errors = 0;
    int                     cycle_count = 0;

    wildcard_glob_matcher_top #(
        .PATTERN_MAX(PATTERN_MAX)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .subject_byte(subject_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .matched     (matched),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [CHAR_W-1:0] pattern_char(int p);
        return pattern_words[p / 8][(p % 8) * 8 +: 8];
    endfunction

    // pattern stops at the first zero byte or the saturated length
    function automatic int effective_length();
        int lim;
        lim = (pattern_len > PATTERN_MAX) ? PATTERN_MAX : int'(pattern_len);
        for (int p = 0; p < lim; p++)
            if (pattern_char(p) == CH_NUL)
                return p;
        return lim;
    endfunction

    function automatic pos_set_t star_closure(pos_set_t v, int len);
        for (int p = 0; p < len; p++)
            if (v[p] && pattern_char(p) == CH_STAR)
                v[p + 1] = 1'b1;
        return v;
    endfunction

    function automatic void rearm_positions();
        active_pos = star_closure(pos_set_t'(1), effective_length());
    endfunction

    function automatic void absorb_subject_byte(logic [CHAR_W-1:0] c);
        int len;
        pos_set_t nxt;
        logic [CHAR_W-1:0] b;
        len = effective_length();
        nxt = '0;
        if (c == CH_NUL)
        begin
            verdict_queue.push_back(active_pos[len]);
            rearm_positions();
        end
        else
        begin
            for (int p = 0; p < len; p++)
            begin
                if (active_pos[p])
                begin
                    b = pattern_char(p);
                    if (b == CH_STAR)
                        nxt[p] = 1'b1;
                    else if ((b == CH_QUESTION && c != CH_DOT) || b == c)
                        nxt[p + 1] = 1'b1;
                end
            end
            active_pos = star_closure(nxt, len);
        end
    endfunction

    // unknown indexes are dropped and leave the string under way alone
    function automatic void apply_register(logic [CFG_INDEX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_PATTERN_LENGTH: pattern_len = data[LEN_W-1:0];
            REG_PATTERN_LO:     pattern_words[0] = data;
            REG_PATTERN_MID_LO: pattern_words[1] = data;
            REG_PATTERN_MID_HI: pattern_words[2] = data;
            REG_PATTERN_HI:     pattern_words[3] = data;
            default:            return;
        endcase
        rearm_positions();
    endfunction

    function automatic logic [CHAR_W-1:0] subject_filler();
        case ($urandom_range(0, 9))
            0, 1, 2: return 8'h61;
            3, 4:    return 8'h62;
            5:       return CH_DOT;
            6:       return 8'h78;
            7:       return CH_STAR;
            8:       return 8'hFF;
            default: return CHAR_W'($urandom_range(1, 255));
        endcase
    endfunction

    function automatic logic [CHAR_W-1:0] pattern_pick();
        int r;
        r = $urandom_range(0, 99);
        if (r < 28)
            return 8'h61;
        if (r < 42)
            return 8'h62;
        if (r < 52)
            return CH_DOT;
        if (r < 72)
            return CH_STAR;
        if (r < 92)
            return CH_QUESTION;
        if (r < 98)
            return CHAR_W'($urandom_range(1, 255));
        return CH_NUL;
    endfunction

    // Builds one terminated string, derived from the current pattern unless
    // noise is asked for; returns the number of words queued.
    function automatic int queue_subject(bit mutate, bit noise);
        logic [CHAR_W-1:0] s [$];
        logic [CHAR_W-1:0] b;
        int len;
        int idx;
        len = effective_length();
        if (noise)
        begin
            repeat ($urandom_range(0, 6))
                s.push_back($urandom_range(0, 1) ? CHAR_W'($urandom_range(1, 255))
                                                 : subject_filler());
        end
        else
        begin
            for (int p = 0; p < len; p++)
            begin
                b = pattern_char(p);
                if (b == CH_STAR)
                    repeat ($urandom_range(0, 3))
                        s.push_back(subject_filler());
                else if (b == CH_QUESTION)
                begin
                    do
                        b = subject_filler();
                    while (b == CH_DOT);
                    s.push_back(b);
                end
                else
                    s.push_back(b);
            end
            if (mutate)
            begin
                if (s.size() == 0)
                    s.push_back(subject_filler());
                else
                begin
                    idx = $urandom_range(0, s.size() - 1);
                    case ($urandom_range(0, 2))
                        0:       s.delete(idx);
                        1:       s.insert(idx, subject_filler());
                        default: s[idx] = subject_filler();
                    endcase
                end
            end
        end
        foreach (s[i])
            subject_queue.push_back(s[i]);
        subject_queue.push_back(CH_NUL);
        return s.size() + 1;
    endfunction

    task automatic send_text(input string s, input bit terminate);
        for (int i = 0; i < s.len(); i++)
            subject_queue.push_back(s[i]);
        if (terminate)
            subject_queue.push_back(CH_NUL);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_register(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        @(posedge clk);
        while (subject_queue.size() != 0 || in_valid || verdict_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic run_random_phase(output int queued);
        logic [CFG_DATA_W-1:0] w [PATTERN_WORDS];
        logic [LEN_W-1:0] len;
        int r;
        int fill;
        r = $urandom_range(0, 99);
        if (r < 10)
            len = 0;
        else if (r < 20)
            len = PATTERN_MAX;
        else if (r < 30)
            len = LEN_W'($urandom_range(PATTERN_MAX + 1, 63));
        else
            len = LEN_W'($urandom_range(1, 12));
        fill = $urandom_range(0, 99);
        for (int i = 0; i < PATTERN_WORDS; i++)
        begin
            if (fill < 10)
                w[i] = {$urandom, $urandom};
            else if (fill < 18)
                w[i] = '1;
            else
                for (int j = 0; j < 8; j++)
                    w[i][j * 8 +: 8] = pattern_pick();
        end
        write_register(REG_PATTERN_LO, w[0]);
        write_register(REG_PATTERN_MID_LO, w[1]);
        if ($urandom_range(0, 3) == 0)
            write_register(CFG_INDEX_W'($urandom_range(REG_PATTERN_HI + 1, REG_UNUSED_TOP)),
                           {$urandom, $urandom});
        write_register(REG_PATTERN_MID_HI, w[2]);
        write_register(REG_PATTERN_HI, w[3]);
        write_register(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
        queued = 0;
        while (queued < STRING_TARGET)
        begin
            r = $urandom_range(0, 99);
            queued += queue_subject(r >= 55 && r < 75, r >= 75);
        end
        // sometimes leave a string open so the next write has to restart it
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 3))
            begin
                subject_queue.push_back(subject_filler());
                queued++;
            end
        wait_idle();
    endtask

    // sender: a stalled word holds until it is taken
    always @(negedge clk)
    begin
        if (!in_valid || in_taken)
        begin
            if (subject_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid     <= 1'b1;
                subject_byte <= subject_queue.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);

    // checks verdicts first, then folds in the word taken at this edge
    always @(posedge clk)
    begin : verdict_check
        logic want;
        in_taken <= in_valid && !in_stall;
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (verdict_queue.size() == 0)
                begin
                    $display("%0t: unexpected verdict, expected none, actual matched=%0b",
                             $time, matched);
                    errors++;
                end
                else
                begin
                    want = verdict_queue.pop_front();
                    if (matched !== want)
                    begin
                        $display("%0t: matched mismatch, expected %0b, actual %0b",
                                 $time, want, matched);
                        errors++;
                    end
                end
            end
            if (in_valid && !in_stall)
                absorb_subject_byte(subject_byte);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("%0t: timed out with %0d verdicts outstanding", $time,
                     verdict_queue.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin : stimulus
        int random_items;
        int queued;
        int mode;
        for (int i = 0; i < PATTERN_WORDS; i++)
            pattern_words[i] = '0;
        rearm_positions();
        send_idle_pct = 12;
        recv_idle_pct = 72;
        repeat (2)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty pattern out of reset: only the empty string matches
        send_text("", 1'b1);
        send_text("a", 1'b1);
        wait_idle();

        // leading stars, '?' refusing a dot, literal dot, top-bit bytes
        write_register(REG_PATTERN_LO,
                       CFG_DATA_W'({CH_DOT, CH_QUESTION, 8'h61, CH_STAR, CH_STAR}));
        write_register(REG_PATTERN_LENGTH, CFG_DATA_W'(5));
        send_text("xab.", 1'b1);
        send_text("a..", 1'b1);
        subject_queue.push_back(8'hFF);
        subject_queue.push_back(8'h61);
        subject_queue.push_back(8'hFF);
        subject_queue.push_back(CH_DOT);
        subject_queue.push_back(CH_NUL);
        wait_idle();

        // unknown index mid-string is ignored; a real write restarts the string
        write_register(REG_PATTERN_LO, CFG_DATA_W'({8'h62, 8'h61}));
        write_register(REG_PATTERN_LENGTH, CFG_DATA_W'(2));
        send_text("a", 1'b0);
        wait_idle();
        write_register(REG_UNUSED_TOP, '1);
        send_text("b", 1'b1);
        send_text("a", 1'b0);
        wait_idle();
        write_register(REG_PATTERN_LENGTH, CFG_DATA_W'(2));
        send_text("b", 1'b1);
        wait_idle();

        // oversized length with a zero byte cutting the pattern short
        write_register(REG_PATTERN_LO, CFG_DATA_W'({CH_STAR, 8'h61}));
        write_register(REG_PATTERN_MID_LO, '1);
        write_register(REG_PATTERN_MID_HI, '1);
        write_register(REG_PATTERN_HI, '1);
        write_register(REG_PATTERN_LENGTH, CFG_DATA_W'(63));
        send_text("ab", 1'b1);
        wait_idle();

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            mode = random_items * 3 / RANDOM_ITEMS;
            case (mode)
                0:
                begin
                    send_idle_pct = 12;
                    recv_idle_pct = 72;
                end
                1:
                begin
                    send_idle_pct = 72;
                    recv_idle_pct = 12;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            run_random_phase(queued);
            random_items += queued;
        end

        wait_idle();
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
